// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the buffer manager modules.
// Each check is sampled on the rising clock edge and is off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every enabled clock edge
`define AST_CHECK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression must never be true at an enabled clock edge
`define AST_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define AST_CHECK(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hdl/smr_pkg.sv =====
// ----------------------------------------------------------------------------
// smr_pkg
// Types, constants and helpers of the persistent buffer manager.
// ----------------------------------------------------------------------------
package smr_pkg;

    // buffer ring geometry
    localparam int SLOTS  = 32;
    localparam int SLOT_W = $clog2(SLOTS);

    // datapath widths
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 23;   // base + 127 * step
    localparam int ZONE_W  = 8;    // zone counter, holds 127 + 1
    localparam int BPZ_W   = 20;
    localparam int STEP_W  = 16;
    localparam int ZCFG_W  = 7;
    localparam int BZ_W    = BPZ_W + ZONE_W;
    localparam int BAND_W  = ADDR_W + 1;
    localparam int ZB_W    = SIZE_W + BPZ_W;
    localparam int SUM_W   = ZB_W + 1;
    localparam int CFG_W   = 20;
    localparam int SAT_W   = 17;
    localparam int BNUM_W  = 26;
    localparam int CNT_W   = 5;
    localparam int DIV_CNT_W = $clog2(ADDR_W);

    // reset values of the geometry registers (4 KiB blocks)
    localparam logic [STEP_W-1:0] RST_BASE  = 16'd4608;
    localparam logic [STEP_W-1:0] RST_STEP  = 16'd256;
    localparam logic [BPZ_W-1:0]  RST_BPZ   = 20'd10220;
    localparam logic [ZCFG_W-1:0] RST_ZONES = 7'd19;

    localparam logic [SAT_W-1:0] SAT_MAX = '1;

    // result kinds
    typedef enum logic [2:0] {
        K_RD_BUF  = 3'd0,
        K_RD_DISK = 3'd1,
        K_WR_BUF  = 3'd2,
        K_BAND_RD = 3'd3,
        K_MERGE   = 3'd4,
        K_BAND_WR = 3'd5
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_STEP  = 2'd1,
        CFG_BPZ   = 2'd2,
        CFG_ZONES = 2'd3
    } t_cfg_idx;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_HIT,
        S_LOC_HEAD,
        S_SCAN,
        S_LOC_POS,
        S_SKIP,
        S_APPEND
    } t_ctl_state;

    // zone walk / divider states
    typedef enum logic [2:0] {
        L_IDLE,
        L_CHK,
        L_CMP,
        L_DIV,
        L_DONE
    } t_loc_state;

    // input word
    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] block_addr;
        logic              end_of_request;
    } t_smr_in;

    // result word
    typedef struct packed {
        logic [2:0]        kind;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] disk_block;
        logic [SAT_W-1:0]  band_blocks;
        logic [SAT_W-1:0]  offset_in_band;
        logic [BNUM_W-1:0] band_number;
        logic [CNT_W-1:0]  merged_count;
        logic              request_done;
        logic              last;
    } t_smr_out;

    // controller to datapath
    typedef struct packed {
        logic  load_in;
        logic  match;
        logic  loc_start;
        logic  loc_sel_pos;
        logic  cap_flush;
        logic  pos_inc;
        logic  pos_to_head;
        logic  head_inc;
        logic  set_moved;
        logic  clr_moved;
        logic  clr_valid;
        logic  append;
        logic  merged_inc;
        logic  emit;
        t_kind kind;
        logic  last;
    } t_smr_cmd;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic hit;
        logic full;
        logic pos_eq_tail;
        logic pos_valid;
        logic loc_done;
        logic band_match;
        logic head_skip;
        logic moved;
    } t_smr_sts;

    // ring pointer increment
    function automatic logic [SLOT_W-1:0] next_ptr(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        if (p == SLOT_W'(SLOTS - 1)) begin
            r = '0;
        end else begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    // saturate a band size or offset to the result field
    function automatic logic [SAT_W-1:0] sat17(input logic [SIZE_W-1:0] v);
        logic [SAT_W-1:0] r;
        if (v > SIZE_W'(SAT_MAX)) begin
            r = SAT_MAX;
        end else begin
            r = v[SAT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/smr_locate.sv =====
// ----------------------------------------------------------------------------
// smr_locate
// Zone walk and bit-serial divide: band index, band size and block offset
// of one disk block address.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smr_locate import smr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [STEP_W-1:0] i_base,
    input  logic [STEP_W-1:0] i_step,
    input  logic [BPZ_W-1:0]  i_bpz,
    input  logic [ZCFG_W-1:0] i_zones,
    output logic              o_done,
    output logic [BAND_W-1:0] o_band,
    output logic [SIZE_W-1:0] o_size,
    output logic [SIZE_W-1:0] o_rem
);

    t_loc_state r_state, n_state;

    logic [ADDR_W-1:0]    r_addr;
    logic [ZONE_W-1:0]    r_z;
    logic [SIZE_W-1:0]    r_sz;
    logic [ADDR_W-1:0]    r_total;
    logic [ZB_W-1:0]      r_zb;
    logic [BZ_W-1:0]      r_bz;
    logic [ADDR_W-1:0]    r_q;
    logic [SIZE_W-1:0]    r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic              w_last_zone;
    logic              w_in_zone;
    logic [SIZE_W:0]   w_shift;
    logic [SIZE_W+1:0] w_sub;

    assign w_last_zone = (r_z == ZONE_W'(i_zones));
    assign w_in_zone   = (SUM_W'(r_total) + SUM_W'(r_zb)) > SUM_W'(r_addr);
    assign w_shift     = {r_rem, r_q[ADDR_W-1]};
    assign w_sub       = {1'b0, w_shift} - (SIZE_W+2)'(r_sz);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            L_IDLE: begin
                if (i_start) n_state = L_CHK;
            end
            L_CHK: begin
                n_state = w_last_zone ? L_DONE : L_CMP;
            end
            L_CMP: begin
                n_state = w_in_zone ? L_DIV : L_CHK;
            end
            L_DIV: begin
                if (r_cnt == DIV_CNT_W'(ADDR_W - 1)) n_state = L_DONE;
            end
            L_DONE: begin
                n_state = L_IDLE;
            end
            default: n_state = L_IDLE;
        endcase
    end

    // walk and divide registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_start) begin
                    r_addr  <= i_addr;
                    r_z     <= '0;
                    r_sz    <= SIZE_W'(i_base);
                    r_total <= '0;
                end
            end
            L_CHK: begin
                // zone size times band count
                r_zb <= ZB_W'(r_sz * i_bpz);
                if (w_last_zone) begin
                    // beyond the last zone: everything reads zero
                    r_bz  <= '0;
                    r_q   <= '0;
                    r_rem <= '0;
                    r_sz  <= '0;
                end
            end
            L_CMP: begin
                if (w_in_zone) begin
                    r_q   <= r_addr - r_total;
                    r_rem <= '0;
                    r_cnt <= '0;
                    r_bz  <= BZ_W'(i_bpz * r_z);
                end else begin
                    r_total <= r_total + r_zb[ADDR_W-1:0];
                    r_sz    <= r_sz + SIZE_W'(i_step);
                    r_z     <= r_z + 1'b1;
                end
            end
            L_DIV: begin
                // one quotient bit per cycle
                r_cnt <= r_cnt + 1'b1;
                if (!w_sub[SIZE_W+1]) begin
                    r_rem <= w_sub[SIZE_W-1:0];
                    r_q   <= {r_q[ADDR_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[SIZE_W-1:0];
                    r_q   <= {r_q[ADDR_W-2:0], 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done = (r_state == L_DONE);
    assign o_band = BAND_W'(r_bz) + BAND_W'(r_q);
    assign o_size = r_sz;
    assign o_rem  = r_rem;

    `AST_CHECK(a_done_pulse, i_clk, i_rst_n, o_done |=> !o_done)
    `AST_NEVER(a_div_zero, i_clk, i_rst_n, (r_state == L_DIV) && (r_sz == '0))

endmodule

// ===== hdl/smr_datapath.sv =====
// ----------------------------------------------------------------------------
// smr_datapath
// Slot tags and valid bits, ring pointers, flush registers, geometry
// registers, the locate unit and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smr_datapath import smr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  t_smr_in           i_in,
    input  t_smr_cmd          i_cmd,
    output t_smr_sts          o_sts,
    output logic              o_res_strobe,
    output t_smr_out          o_res
);

    // geometry registers
    logic [STEP_W-1:0] r_base, r_step;
    logic [BPZ_W-1:0]  r_bpz;
    logic [ZCFG_W-1:0] r_zones;

    // slot store
    logic [SLOTS-1:0]  r_valid;
    logic [ADDR_W-1:0] r_tag [SLOTS];
    logic [SLOTS-1:0]  r_hit_vec;

    // ring and flush state
    logic [SLOT_W-1:0] r_head, r_tail, r_pos;
    logic              r_moved;
    logic [BAND_W-1:0] r_lband;
    logic [SIZE_W-1:0] r_lsize;
    logic [ADDR_W-1:0] r_start;
    logic [CNT_W-1:0]  r_merged;
    t_smr_in           r_in;

    // result register
    logic     r_strobe;
    t_smr_out r_res, n_res;

    logic              w_hit;
    logic [SLOT_W-1:0] w_hit_idx;
    logic [SLOT_W-1:0] w_loc_sel;
    logic              w_loc_done;
    logic [BAND_W-1:0] w_loc_band;
    logic [SIZE_W-1:0] w_loc_size, w_loc_rem;
    logic [ADDR_W-1:0] w_loc_start;
    logic              w_full;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= RST_BASE;
            r_step  <= RST_STEP;
            r_bpz   <= RST_BPZ;
            r_zones <= RST_ZONES;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BASE:  r_base  <= i_cfg_data[STEP_W-1:0];
                CFG_STEP:  r_step  <= i_cfg_data[STEP_W-1:0];
                CFG_BPZ:   r_bpz   <= i_cfg_data[BPZ_W-1:0];
                CFG_ZONES: r_zones <= i_cfg_data[ZCFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // lowest matching slot
    always_comb begin
        w_hit     = |r_hit_vec;
        w_hit_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) w_hit_idx = SLOT_W'(i);
        end
    end

    assign w_full = (next_ptr(r_tail) == r_head);

    // locate unit on one tag
    assign w_loc_sel = i_cmd.loc_sel_pos ? r_pos : r_head;

    smr_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.loc_start),
        .i_addr  (r_tag[w_loc_sel]),
        .i_base  (r_base),
        .i_step  (r_step),
        .i_bpz   (r_bpz),
        .i_zones (r_zones),
        .o_done  (w_loc_done),
        .o_band  (w_loc_band),
        .o_size  (w_loc_size),
        .o_rem   (w_loc_rem)
    );

    assign w_loc_start = r_tag[r_head] - ADDR_W'(w_loc_rem);

    // input word, tag compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) r_in <= i_in;
        if (i_cmd.match) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_hit_vec[i] <= r_valid[i] && (r_tag[i] == r_in.block_addr);
            end
        end
        if (i_cmd.append) r_tag[r_tail] <= r_in.block_addr;
    end

    // valid bits and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            if (i_cmd.clr_valid) r_valid[r_pos] <= 1'b0;
            if (i_cmd.head_inc)  r_head <= next_ptr(r_head);
            if (i_cmd.append) begin
                r_valid[r_tail] <= 1'b1;
                r_tail          <= next_ptr(r_tail);
            end
        end
    end

    // flush bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_flush) begin
            r_lband  <= w_loc_band;
            r_lsize  <= w_loc_size;
            r_start  <= w_loc_start;
            r_pos    <= r_head;
            r_merged <= '0;
        end else begin
            if (i_cmd.pos_inc)     r_pos <= next_ptr(r_pos);
            if (i_cmd.pos_to_head) r_pos <= r_head;
            if (i_cmd.merged_inc)  r_merged <= r_merged + 1'b1;
        end
        if (i_cmd.set_moved) r_moved <= 1'b1;
        if (i_cmd.clr_moved) r_moved <= 1'b0;
    end

    // status back to the controller
    always_comb begin
        o_sts.op          = r_in.op;
        o_sts.hit         = w_hit;
        o_sts.full        = w_full;
        o_sts.pos_eq_tail = (r_pos == r_tail);
        o_sts.pos_valid   = r_valid[r_pos];
        o_sts.loc_done    = w_loc_done;
        o_sts.band_match  = (w_loc_band == r_lband);
        o_sts.head_skip   = !r_valid[r_head] && (r_head != r_tail);
        o_sts.moved       = r_moved;
    end

    // result word by kind
    always_comb begin
        n_res              = '0;
        n_res.kind         = i_cmd.kind;
        n_res.last         = i_cmd.last;
        n_res.request_done = i_cmd.last & r_in.end_of_request;
        case (i_cmd.kind)
            K_RD_BUF: n_res.slot = w_hit_idx;
            K_RD_DISK: n_res.disk_block = r_in.block_addr;
            K_WR_BUF: n_res.slot = w_hit ? w_hit_idx : r_tail;
            K_BAND_RD: begin
                n_res.disk_block  = w_loc_start;
                n_res.band_blocks = sat17(w_loc_size);
                n_res.band_number = w_loc_band[BNUM_W-1:0];
            end
            K_MERGE: begin
                n_res.slot           = r_pos;
                n_res.offset_in_band = sat17(w_loc_rem);
                n_res.band_number    = r_lband[BNUM_W-1:0];
            end
            K_BAND_WR: begin
                n_res.disk_block   = r_start;
                n_res.band_blocks  = sat17(r_lsize);
                n_res.band_number  = r_lband[BNUM_W-1:0];
                n_res.merged_count = r_merged;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
        end
        if (i_cmd.emit) r_res <= n_res;
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    `AST_NEVER(a_append_full, i_clk, i_rst_n, i_cmd.append && w_full)
    `AST_NEVER(a_clr_invalid, i_clk, i_rst_n, i_cmd.clr_valid && !r_valid[r_pos])

endmodule

// ===== hdl/smr_ctrl.sv =====
// ----------------------------------------------------------------------------
// smr_ctrl
// Sequencer: lookup, hit/miss decision, band flush walk and append.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module smr_ctrl import smr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_smr_sts i_sts,
    output t_smr_cmd o_cmd,
    output logic     o_busy
);

    t_ctl_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_HIT;
            end
            S_HIT: begin
                if (!i_sts.op) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.kind = i_sts.hit ? K_RD_BUF : K_RD_DISK;
                    n_state    = S_IDLE;
                end else if (i_sts.hit) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.kind = K_WR_BUF;
                    n_state    = S_IDLE;
                end else if (i_sts.full) begin
                    // ring full: flush the head's band first
                    o_cmd.loc_start = 1'b1;
                    n_state         = S_LOC_HEAD;
                end else begin
                    n_state = S_APPEND;
                end
            end
            S_LOC_HEAD: begin
                if (i_sts.loc_done) begin
                    o_cmd.cap_flush = 1'b1;
                    o_cmd.emit      = 1'b1;
                    o_cmd.kind      = K_BAND_RD;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.pos_eq_tail) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = K_BAND_WR;
                    n_state    = S_APPEND;
                end else if (!i_sts.pos_valid) begin
                    o_cmd.pos_inc = 1'b1;
                end else begin
                    o_cmd.loc_start   = 1'b1;
                    o_cmd.loc_sel_pos = 1'b1;
                    n_state           = S_LOC_POS;
                end
            end
            S_LOC_POS: begin
                if (i_sts.loc_done) begin
                    if (i_sts.band_match) begin
                        o_cmd.emit       = 1'b1;
                        o_cmd.kind       = K_MERGE;
                        o_cmd.merged_inc = 1'b1;
                        o_cmd.clr_valid  = 1'b1;
                        o_cmd.clr_moved  = 1'b1;
                        n_state          = S_SKIP;
                    end else begin
                        o_cmd.pos_inc = 1'b1;
                        n_state       = S_SCAN;
                    end
                end
            end
            S_SKIP: begin
                // advance head past invalid slots, one per cycle
                if (i_sts.head_skip) begin
                    o_cmd.head_inc  = 1'b1;
                    o_cmd.set_moved = 1'b1;
                end else begin
                    if (i_sts.moved) begin
                        o_cmd.pos_to_head = 1'b1;
                    end else begin
                        o_cmd.pos_inc = 1'b1;
                    end
                    n_state = S_SCAN;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                o_cmd.emit   = 1'b1;
                o_cmd.last   = 1'b1;
                o_cmd.kind   = K_WR_BUF;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    `AST_CHECK(a_last_idle, i_clk, i_rst_n, (o_cmd.emit && o_cmd.last) |=> r_state == S_IDLE)
    `AST_NEVER(a_emit_idle, i_clk, i_rst_n, !o_busy && o_cmd.emit)

endmodule

// ===== hdl/smr_persistent_buffer_manager.sv =====
// ----------------------------------------------------------------------------
// smr_persistent_buffer_manager
// Persistent buffer controller for a banded disk: slot lookup, append and
// band flush, one block access per command.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low; o_busy then
// stays high until the command's last result word has been issued. Results
// appear on o_res for one cycle each, flagged by o_res_strobe, and must be
// captured then: the block cannot be held off. A read or a write hit passes
// the idle, match and hit states; a write miss with room in the ring also
// passes the append state. A write miss on a full ring flushes one band
// first; each slot examined runs the zone walk (a check and a compare
// state per zone passed) and a 32-step serial divider, a merged slot then
// passes the head skip state, and invalid slots are stepped over one at a
// time. Geometry registers may be written only while o_busy is low.
// ----------------------------------------------------------------------------
module smr_persistent_buffer_manager import smr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  t_smr_in          i_cmd,
    output logic             o_res_strobe,
    output t_smr_out         o_res,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_smr_cmd w_cmd;
    t_smr_sts w_sts;
    logic     w_busy;

    smr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    smr_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in         (i_cmd),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    assign o_busy = w_busy;

endmodule
